### sv/qbsc_pkg.sv
// Package for the quadratic Bezier scanline crossing pipeline.
// Holds word types, derived widths and rounding constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qbsc_pkg;

	localparam int CW   = 24;                    // coordinate width
	localparam int TF   = 16;                    // fraction bits of t
	localparam int AW   = CW + 2;                // signed A
	localparam int BW   = CW + 1;                // signed b and c
	localparam int DW   = CW + 1;                // divisor magnitude
	localparam int DSW  = 2 * CW + 3;            // discriminant
	localparam int SQW  = (DSW + 2 * TF + 1) / 2; // root bits
	localparam int RADW = 2 * SQW;               // radicand
	localparam int SRW  = SQW + 2;               // root remainder
	localparam int NW   = SQW + 3;               // dividend
	localparam int QB   = TF + 1;                // quotient bits
	localparam int P1W  = QB + CW + 2;
	localparam int P2W  = QB + CW + 3;
	localparam int ACW  = P2W + 1;
	localparam int RXW  = ACW - TF + 1;
	localparam int XW   = RXW + 1;

	localparam logic [QB-1:0] T_ONE = QB'(1 << TF);
	localparam int HALF = 1 << (TF - 1);

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] ctrl_x;
		logic signed [CW-1:0] ctrl_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] scan_y;
	} in_word_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] cross_x;
		logic                 falling;
	} out_word_t;

	typedef struct packed {
		logic signed [AW-1:0] a;
		logic signed [BW-1:0] b;
		logic signed [BW-1:0] c;
		logic signed [CW-1:0] sx;
		logic signed [CW:0]   dx1;
		logic signed [CW+1:0] ddx;
		logic                 fall;
		logic                 lin;
		logic                 live;
	} ctx_t;

endpackage
`default_nettype wire

### sv/quad_bezier_scanline_crossing.sv
// Quadratic Bezier / scanline crossing, fully pipelined.
// Stages from accepted input word to output word: decode 3,
// square root 42, divide setup 3, divide 17, select and x evaluation 6.
// Throughput: one word per cycle; the whole pipe holds while the output
// word waits. Reset clears all valid bits; data registers are not reset.
// Depends on qbsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module quad_bezier_scanline_crossing (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire qbsc_pkg::in_word_t  in_data,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      qbsc_pkg::out_word_t out_data
);
	import qbsc_pkg::*;

	localparam int NST = 3 + SQW + 3 + QB + 6;

	typedef struct packed {
		logic [SRW-1:0] rem;
		logic [SQW-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] q;
	} dv_t;

	typedef struct packed {
		logic ovf1;
		logic ovf2;
		logic neg1;
		logic neg2;
	} dvf_t;

	function automatic sq_t sq_step(sq_t cur, logic [1:0] pr);
		logic [SRW-1:0] r;
		logic [SRW-1:0] tr;
		sq_t nx;
		r  = {cur.rem[SRW-3:0], pr};
		tr = {cur.root, 2'b01};
		if (r >= tr) begin
			nx.rem  = r - tr;
			nx.root = {cur.root[SQW-2:0], 1'b1};
		end else begin
			nx.rem  = r;
			nx.root = {cur.root[SQW-2:0], 1'b0};
		end
		return nx;
	endfunction

	function automatic dv_t dv_step(dv_t cur, logic nb, logic [DW-1:0] d);
		logic [DW:0] r;
		dv_t nx;
		r = {cur.rem, nb};
		if (r >= {1'b0, d}) begin
			nx.rem = DW'(r - {1'b0, d});
			nx.q   = {cur.q[QB-2:0], 1'b1};
		end else begin
			nx.rem = DW'(r);
			nx.q   = {cur.q[QB-2:0], 1'b0};
		end
		return nx;
	endfunction

	logic           adv;
	logic [NST-1:0] vld_q;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// decode
	ctx_t c1_d, c3_d, ctx_s1, ctx_s2, ctx_s3;
	always_comb begin
		c1_d      = '0;
		c1_d.a    = AW'(in_data.start_y) - (AW'(in_data.ctrl_y) <<< 1) + AW'(in_data.end_y);
		c1_d.b    = BW'(in_data.ctrl_y) - BW'(in_data.start_y);
		c1_d.c    = BW'(in_data.start_y) - BW'(in_data.scan_y);
		c1_d.sx   = in_data.start_x;
		c1_d.dx1  = (CW+1)'(in_data.ctrl_x) - (CW+1)'(in_data.start_x);
		c1_d.ddx  = (CW+2)'(in_data.start_x) - ((CW+2)'(in_data.ctrl_x) <<< 1)
			+ (CW+2)'(in_data.end_x);
		c1_d.fall = in_data.end_y < in_data.start_y;
		c1_d.lin  = (c1_d.a == '0);
		c1_d.live = 1'b0;
	end

	// b*b and |A*C|
	logic [CW-1:0]   magb, magc;
	logic [AW-2:0]   maga;
	logic [2*CW-1:0] bb_s2;
	logic [AW+CW-2:0] ac_s2;
	logic            acpos_s2;
	assign magb = ctx_s1.b[BW-1] ? CW'(-ctx_s1.b) : CW'(ctx_s1.b);
	assign magc = ctx_s1.c[BW-1] ? CW'(-ctx_s1.c) : CW'(ctx_s1.c);
	assign maga = ctx_s1.a[AW-1] ? (AW-1)'(-ctx_s1.a) : (AW-1)'(ctx_s1.a);

	// discriminant
	logic [DSW-1:0] disc_d, disc_s3;
	logic           ok_d;
	always_comb begin
		ok_d = 1'b1;
		if (!acpos_s2) begin
			disc_d = DSW'(bb_s2) + DSW'(ac_s2);
		end else if (DSW'(ac_s2) > DSW'(bb_s2)) begin
			ok_d   = 1'b0;
			disc_d = DSW'(bb_s2);
		end else begin
			disc_d = DSW'(bb_s2) - DSW'(ac_s2);
		end
	end

	always_comb begin
		c3_d      = ctx_s2;
		c3_d.live = ctx_s2.lin ? (ctx_s2.b != '0) : ok_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1   <= c1_d;
			ctx_s2   <= ctx_s1;
			bb_s2    <= magb * magb;
			ac_s2    <= maga * magc;
			acpos_s2 <= (ctx_s1.a[AW-1] == ctx_s1.c[BW-1]) && (ctx_s1.c != '0);
			ctx_s3   <= c3_d;
			disc_s3  <= disc_d;
		end
	end

	// square root, one bit per stage
	sq_t            sq_s   [SQW];
	logic [DSW-1:0] sqd_s  [SQW];
	ctx_t           sqc_s  [SQW];

	for (genvar k = 0; k < SQW; k++) begin : g_sq
		sq_t            prv;
		logic [DSW-1:0] pd;
		ctx_t           pc;
		logic [RADW-1:0] rad;
		if (k == 0) begin : g_first
			assign prv = '0;
			assign pd  = disc_s3;
			assign pc  = ctx_s3;
		end else begin : g_next
			assign prv = sq_s[k-1];
			assign pd  = sqd_s[k-1];
			assign pc  = sqc_s[k-1];
		end
		assign rad = {(RADW-2*TF)'(pd), {(2*TF){1'b0}}};
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k]  <= sq_step(prv, rad[RADW-1-2*k -: 2]);
				sqd_s[k] <= pd;
				sqc_s[k] <= pc;
			end
		end
	end

	// numerators and divisor
	logic signed [NW-1:0] nb, se, n1_d, n2_d, n1_sn, n2_sn;
	logic signed [AW-1:0] den_d, den_sn;
	ctx_t                 ctx_sn;
	ctx_t                 cq;
	assign cq   = sqc_s[SQW-1];
	assign nb   = NW'(cq.b) <<< TF;
	assign se   = $signed(NW'(sq_s[SQW-1].root));
	assign n1_d = cq.lin ? -(NW'(cq.c) <<< TF) : se - nb;
	assign n2_d = -nb - se;
	assign den_d = cq.lin ? (AW'(cq.b) <<< 1) : cq.a;

	// magnitudes plus rounding half
	logic [NW-1:0] m1, m2, nn1_sa, nn2_sa;
	logic [DW-1:0] dm, dm_sa;
	dvf_t          f_sa;
	ctx_t          ctx_sa;
	assign m1 = n1_sn[NW-1] ? NW'(-n1_sn) : NW'(n1_sn);
	assign m2 = n2_sn[NW-1] ? NW'(-n2_sn) : NW'(n2_sn);
	assign dm = den_sn[AW-1] ? DW'(-den_sn) : DW'(den_sn);

	// overflow test and initial remainder
	dv_t           dv1_so, dv2_so;
	logic [QB-1:0] lo1_so, lo2_so;
	logic [DW-1:0] dm_so;
	dvf_t          f_so;
	ctx_t          ctx_so;

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_sn  <= n1_d;
			n2_sn  <= n2_d;
			den_sn <= den_d;
			ctx_sn <= cq;

			nn1_sa <= m1 + NW'(dm >> 1);
			nn2_sa <= m2 + NW'(dm >> 1);
			dm_sa  <= dm;
			f_sa.ovf1 <= 1'b0;
			f_sa.ovf2 <= 1'b0;
			f_sa.neg1 <= n1_sn[NW-1] != den_sn[AW-1];
			f_sa.neg2 <= n2_sn[NW-1] != den_sn[AW-1];
			ctx_sa <= ctx_sn;

			dv1_so.rem <= DW'(nn1_sa >> QB);
			dv1_so.q   <= '0;
			dv2_so.rem <= DW'(nn2_sa >> QB);
			dv2_so.q   <= '0;
			lo1_so     <= nn1_sa[QB-1:0];
			lo2_so     <= nn2_sa[QB-1:0];
			dm_so      <= dm_sa;
			f_so.neg1  <= f_sa.neg1;
			f_so.neg2  <= f_sa.neg2;
			f_so.ovf1  <= nn1_sa >= (NW'(dm_sa) << QB);
			f_so.ovf2  <= nn2_sa >= (NW'(dm_sa) << QB);
			ctx_so     <= ctx_sa;
		end
	end

	// two dividers, one quotient bit per stage
	dv_t           dv1_s [QB];
	dv_t           dv2_s [QB];
	logic [QB-1:0] lo1_s [QB];
	logic [QB-1:0] lo2_s [QB];
	logic [DW-1:0] dm_s  [QB];
	dvf_t          f_s   [QB];
	ctx_t          dc_s  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_dv
		dv_t           p1, p2;
		logic [QB-1:0] pl1, pl2;
		logic [DW-1:0] pdm;
		dvf_t          pf;
		ctx_t          pc;
		if (k == 0) begin : g_first
			assign p1  = dv1_so;
			assign p2  = dv2_so;
			assign pl1 = lo1_so;
			assign pl2 = lo2_so;
			assign pdm = dm_so;
			assign pf  = f_so;
			assign pc  = ctx_so;
		end else begin : g_next
			assign p1  = dv1_s[k-1];
			assign p2  = dv2_s[k-1];
			assign pl1 = lo1_s[k-1];
			assign pl2 = lo2_s[k-1];
			assign pdm = dm_s[k-1];
			assign pf  = f_s[k-1];
			assign pc  = dc_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv1_s[k] <= dv_step(p1, pl1[QB-1-k], pdm);
				dv2_s[k] <= dv_step(p2, pl2[QB-1-k], pdm);
				lo1_s[k] <= pl1;
				lo2_s[k] <= pl2;
				dm_s[k]  <= pdm;
				f_s[k]   <= pf;
				dc_s[k]  <= pc;
			end
		end
	end

	// root choice
	logic          in1, in2;
	logic [QB-1:0] q1, q2;
	dvf_t          fl;
	ctx_t          cd;
	assign q1  = dv1_s[QB-1].q;
	assign q2  = dv2_s[QB-1].q;
	assign fl  = f_s[QB-1];
	assign cd  = dc_s[QB-1];
	assign in1 = !fl.ovf1 && (fl.neg1 ? (q1 == '0) : (q1 <= T_ONE));
	assign in2 = !fl.ovf2 && (fl.neg2 ? (q2 == '0) : (q2 <= T_ONE));

	logic [QB-1:0] t_sl;
	logic          hit_sl, hit_m1, hit_m2, hit_m3, hit_m4;
	ctx_t          ctx_sl, ctx_m1, ctx_m2, ctx_m3, ctx_m4;

	// x evaluation
	logic [2*QB-1:0]       tsq_m1;
	logic signed [P1W-1:0] p1_m1, p1_m2;
	logic signed [P2W-1:0] p2_m2;
	logic [QB-1:0]         tt;
	logic signed [ACW-1:0] acc_m3;
	logic [ACW-1:0]        am;
	logic [RXW-1:0]        rr;
	logic signed [RXW-1:0] rx_m4;
	logic signed [XW-1:0]  xs;
	logic signed [CW-1:0]  xc;

	assign tt = QB'((tsq_m1 + (2*QB)'(HALF)) >> TF);
	assign am = acc_m3[ACW-1] ? ACW'(-acc_m3) : ACW'(acc_m3);
	assign rr = RXW'((am + ACW'(HALF)) >> TF);
	assign xs = XW'(ctx_m4.sx) + XW'(rx_m4);
	always_comb begin
		if (xs[XW-1:CW-1] == '0 || xs[XW-1:CW-1] == '1) begin
			xc = CW'(xs);
		end else begin
			xc = {xs[XW-1], {(CW-1){!xs[XW-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_sl   <= in1 ? (fl.neg1 ? '0 : q1) : (fl.neg2 ? '0 : q2);
			hit_sl <= cd.live && (in1 || (!cd.lin && in2));
			ctx_sl <= cd;

			tsq_m1 <= t_sl * t_sl;
			p1_m1  <= $signed({1'b0, t_sl}) * ctx_sl.dx1;
			hit_m1 <= hit_sl;
			ctx_m1 <= ctx_sl;

			p1_m2  <= p1_m1;
			p2_m2  <= $signed({1'b0, tt}) * ctx_m1.ddx;
			hit_m2 <= hit_m1;
			ctx_m2 <= ctx_m1;

			acc_m3 <= (ACW'(p1_m2) <<< 1) + ACW'(p2_m2);
			hit_m3 <= hit_m2;
			ctx_m3 <= ctx_m2;

			rx_m4  <= acc_m3[ACW-1] ? -$signed(rr) : $signed(rr);
			hit_m4 <= hit_m3;
			ctx_m4 <= ctx_m3;

			out_data.hit     <= hit_m4;
			out_data.cross_x <= hit_m4 ? xc : '0;
			out_data.falling <= hit_m4 && ctx_m4.fall;
		end
	end

endmodule
`default_nettype wire

### sv/qbsc_check.sv
// Port-level checker for quad_bezier_scanline_crossing, bound to the top.
// Depends on qbsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qbsc_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire qbsc_pkg::in_word_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire qbsc_pkg::out_word_t out_data
);
	import qbsc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.cross_x == '0 && !out_data.falling)
		else $error("miss word carries data");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("not ready while output drains");

endmodule

bind quad_bezier_scanline_crossing qbsc_check u_qbsc_check (.*);
`default_nettype wire

### sim/quad_bezier_scanline_crossing_tb.sv
// Testbench for quad_bezier_scanline_crossing: drives curve/scanline words with random
// idle gaps and checks every result word against a bit-accurate crossing predictor.
// Depends on qbsc_pkg and the quad_bezier_scanline_crossing RTL.
`timescale 1ns / 1ps
`default_nettype none
module quad_bezier_scanline_crossing_tb;
	import qbsc_pkg::*;

	localparam int N_RANDOM    = 1630;
	localparam int WATCHDOG    = 5000;
	localparam int DRAIN       = 200;

	class crossing_board;
		out_word_t pending[$];
		int        errors;
		int        checked;
		int        hits;

		function automatic longint rnd_div(longint n, longint d);
			longint un, ud, q;
			un = (n < 0) ? -n : n;
			ud = (d < 0) ? -d : d;
			if (ud == 0)
				return 0;
			q = (un + ud / 2) / ud;
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		function automatic logic [127:0] isqrt(logic [127:0] v);
			logic [63:0]  r;
			logic [63:0]  c;
			logic [127:0] sq;
			r = 0;
			for (int i = 63; i >= 0; i--) begin
				c = r | (64'd1 << i);
				sq = {64'd0, c} * {64'd0, c};
				if (sq <= v)
					r = c;
			end
			return {64'd0, r};
		endfunction

		function automatic out_word_t crossing(in_word_t w);
			longint one, cmax, cmin, sx, sy, cx, cy, ex, ey, sc;
			longint a, b, c, t, x, s, tt, acc;
			logic signed [127:0] disc;
			logic        hit;
			out_word_t   r;
			one  = 64'sd1 <<< TF;
			cmax = (64'sd1 <<< (CW - 1)) - 1;
			cmin = -cmax - 1;
			sx = w.start_x; sy = w.start_y; cx = w.ctrl_x; cy = w.ctrl_y;
			ex = w.end_x; ey = w.end_y; sc = w.scan_y;
			a = sy - 2 * cy + ey;
			b = cy - sy;
			c = sy - sc;
			t = 0;
			x = 0;
			hit = 0;
			if (a == 0) begin
				if (b != 0) begin
					t = rnd_div(-c * one, 2 * b);
					hit = (t >= 0 && t <= one);
				end
			end else begin
				disc = 128'(b) * 128'(b) - 128'(a) * 128'(c);
				if (disc >= 0) begin
					s = longint'(isqrt(disc <<< (2 * TF)));
					t = rnd_div(-b * one + s, a);
					if (t < 0 || t > one)
						t = rnd_div(-b * one - s, a);
					hit = (t >= 0 && t <= one);
				end
			end
			if (hit) begin
				tt = rnd_div(t * t, one);
				acc = 2 * t * (cx - sx) + tt * (sx - 2 * cx + ex);
				x = sx + rnd_div(acc, one);
				if (x > cmax) x = cmax;
				if (x < cmin) x = cmin;
			end
			r.hit     = hit;
			r.cross_x = hit ? CW'(x) : '0;
			r.falling = hit && (ey < sy);
			return r;
		endfunction

		function void note_input(in_word_t w);
			pending = {pending, crossing(w)};
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.hit) hits++;
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, got.hit);
				errors++;
			end
			if (got.cross_x !== e.cross_x) begin
				$error("cross_x: expected %0d, got %0d", e.cross_x, got.cross_x);
				errors++;
			end
			if (got.falling !== e.falling) begin
				$error("falling: expected %0d, got %0d", e.falling, got.falling);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	crossing_board board;
	int  idle_cycles;

	quad_bezier_scanline_crossing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [CW-1:0] rcoord();
		case ($urandom_range(0, 5))
		0: return {1'b0, {(CW-1){1'b1}}};
		1: return {1'b1, {(CW-1){1'b0}}};
		2: return CW'($urandom);
		3: return CW'($signed($urandom_range(0, 255)) - 128);
		default: return CW'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
		endcase
	endfunction

	// Mostly curves whose scanline lies inside their y span, so roots land in range.
	function automatic in_word_t rand_curve();
		in_word_t w;
		longint lo, hi;
		w.start_x = rcoord(); w.ctrl_x = rcoord(); w.end_x = rcoord();
		w.start_y = rcoord(); w.ctrl_y = rcoord(); w.end_y = rcoord();
		if ($urandom_range(0, 9) < 7) begin
			lo = w.start_y; hi = w.end_y;
			if (lo > hi) begin lo = w.end_y; hi = w.start_y; end
			w.scan_y = CW'(lo + longint'($urandom) % (hi - lo + 1));
		end else if ($urandom_range(0, 1)) begin
			w.scan_y = w.ctrl_y;
		end else begin
			w.scan_y = rcoord();
		end
		if ($urandom_range(0, 15) == 0)
			w.ctrl_y = CW'((longint'(w.start_y) + longint'(w.end_y)) / 2);
		return w;
	endfunction

	function automatic in_word_t mk(longint sx, longint sy, longint cx, longint cy,
			longint ex, longint ey, longint sc);
		in_word_t w;
		w.start_x = CW'(sx); w.start_y = CW'(sy); w.ctrl_x = CW'(cx);
		w.ctrl_y = CW'(cy); w.end_x = CW'(ex); w.end_y = CW'(ey); w.scan_y = CW'(sc);
		return w;
	endfunction

	task automatic send(in_word_t w);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		board.note_input(w);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver stalls: random runs of ready low/high, with long stretches of always-ready.
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 100)) @(posedge clk);
			end else begin
				n = $urandom_range(0, 8);
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired, %0d words still expected", board.pending.size());
				$display("quad_bezier_scanline_crossing regression: fail");
				$finish;
			end
		end
	end

	initial begin
		longint mx, mn;
		board = new();
		idle_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		mx = (64'sd1 <<< (CW - 1)) - 1;
		mn = -mx - 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// flat curve, linear rising/falling, negative discriminant, endpoints, extremes
		send(mk(0, 0, 0, 0, 0, 0, 0));
		send(mk(100, 64, 200, 64, 300, 64, 64));
		send(mk(0, 0, 640, 640, 1280, 1280, 640));
		send(mk(0, 1280, 640, 640, 1280, 0, 320));
		send(mk(0, 0, 640, 1280, 1280, 0, 2000));
		send(mk(0, 0, 640, 1280, 1280, 0, 300));
		send(mk(5, 0, 7, 1280, 9, 0, 0));
		send(mk(5, 0, 7, 1280, 9, 0, 640));
		send(mk(0, 0, 64, 0, 128, 64, 64));
		send(mk(mx, mn, mn, mx, mx, mn, 0));
		send(mk(mn, mx, mx, mn, mn, mx, mx));
		send(mk(mx, mn, mx, mx, mx, mx, mn));
		send(mk(mn, mn, mn, mn, mn, mn, mn));
		send(mk(mx, mx, mx, mx, mx, mx, mx));
		send(mk(mn, mn, mx, 0, mx, mx, 0));
		send(mk(mx, 0, mn, 0, mx, 0, 1));
		send(mk(-1, -1, -1, -1, -1, -1, -1));
		send(mk(mx, mn, mn, mn, mx, mx, mx));
		send(mk(0, 0, 0, 1, 0, 0, 0));
		send(mk(0, 0, 0, 1, 0, 0, 1));
		for (int i = 0; i < N_RANDOM; i++)
			send(rand_curve());
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("checked %0d result words, %0d of them crossings", board.checked,
			board.hits);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("quad_bezier_scanline_crossing regression: pass");
		else
			$display("quad_bezier_scanline_crossing regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
